// ----- sv/gini_coefficient_sorted_macros.svh -----
// ----------------------------------------------------------------------------
// Gini coefficient block: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GINI_COEFFICIENT_SORTED_MACROS_SVH
`define GINI_COEFFICIENT_SORTED_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/gcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Gini coefficient block: package
// Payload types, controller state, command and status groups, fixed widths.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int GINI_W    = 17;
  localparam int ITEM_W    = 13;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  localparam logic [GINI_W-1:0] Q_ONE = 17'h10000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_last;
  } gcs_req_t;

  typedef struct packed {
    logic [GINI_W-1:0] gini_q16;
    logic [ITEM_W-1:0] item_count;
    logic              zero_total;
    logic              count_overflow;
  } gcs_rsp_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL,
    ST_SUB,
    ST_CMP,
    ST_DIV,
    ST_EMIT
  } gcs_state_t;

  typedef struct packed {
    logic accum;
    logic mul;
    logic sub;
    logic cmp;
    logic div_step;
    logic load_out;
  } gcs_cmd_t;

  typedef struct packed {
    logic need_div;
  } gcs_status_t;

endpackage

// ----- sv/gcs_datapath.sv -----
// ----------------------------------------------------------------------------
// Gini coefficient block: datapath
// Running totals, the final product and difference, the restoring divider
// for the fraction, and the result register.
// ----------------------------------------------------------------------------
module gcs_datapath import gcs_pkg::*; #(
  parameter int MAX_N       = 4096,
  parameter int SAMPLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  gcs_cmd_t    cmd,
  input  gcs_req_t    req,
  output gcs_status_t status,
  output gcs_rsp_t    rsp
);

  localparam int NW = $clog2(MAX_N + 1);
  localparam int TW = SAMPLE_BITS + NW;
  localparam int WW = SAMPLE_BITS + 2 * NW;
  localparam int DW = TW + NW;
  localparam int CW = WW + 1;
  localparam int PW = NW + SAMPLE_BITS;

  logic [NW-1:0]          n;
  logic [WW-1:0]          wsum;
  logic [TW-1:0]          tsum;
  logic                   dropped;
  logic [DW-1:0]          den;
  logic                   zero;
  logic [CW-1:0]          num;
  logic                   pos;
  logic [CW-1:0]          rem;
  logic [GINI_W-1:0]      q;

  logic [SAMPLE_BITS-1:0] x;
  logic [NW-1:0]          idx;
  logic [PW-1:0]          prod;
  logic [DW-1:0]          den_prod;
  logic [CW-1:0]          lhs;
  logic [CW-1:0]          sub;
  logic [CW-1:0]          den_ext;
  logic [CW-1:0]          shifted;
  logic                   ge;
  logic                   room;
  logic                   nonneg;
  logic [NW+ITEM_W-1:0]   n_ext;

  assign x        = req.sample[SAMPLE_BITS-1:0];
  assign idx      = n + NW'(1);
  assign prod     = PW'(idx) * PW'(x);
  assign room     = n < NW'(MAX_N);
  assign den_prod = DW'(n) * DW'(tsum);
  assign lhs      = {wsum, 1'b0};
  assign sub      = CW'(den) + CW'(tsum);
  assign den_ext  = CW'(den);
  assign shifted  = {rem[CW-2:0], 1'b0};
  assign ge       = shifted >= den_ext;
  assign nonneg   = !zero && pos;
  assign n_ext    = {{ITEM_W{1'b0}}, n};

  assign status.need_div = nonneg && (num < den_ext);

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      n       <= '0;
      wsum    <= '0;
      tsum    <= '0;
      dropped <= 1'b0;
    end else if (cmd.accum) begin
      if (room) begin
        n    <= idx;
        wsum <= wsum + WW'(prod);
        tsum <= tsum + TW'(x);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      den  <= den_prod;
      zero <= (n == '0) || (tsum == '0);
    end
    if (cmd.sub) begin
      pos <= lhs > sub;
      num <= lhs - sub;
    end
    if (cmd.cmp) begin
      rem <= num;
      if (status.need_div) begin
        q <= '0;
      end else if (nonneg) begin
        q <= Q_ONE;
      end else begin
        q <= '0;
      end
    end else if (cmd.div_step) begin
      rem <= ge ? (shifted - den_ext) : shifted;
      q   <= {q[GINI_W-2:0], ge};
    end
    if (cmd.load_out) begin
      rsp.gini_q16       <= q;
      rsp.item_count     <= n_ext[ITEM_W-1:0];
      rsp.zero_total     <= zero;
      rsp.count_overflow <= dropped;
    end
  end

endmodule

// ----- sv/gcs_controller.sv -----
// ----------------------------------------------------------------------------
// Gini coefficient block: controller
// Sequences accumulation, the final arithmetic steps, the divider and the
// hand-off of the result register.
// ----------------------------------------------------------------------------
`include "gini_coefficient_sorted_macros.svh"

module gcs_controller import gcs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_last,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  input  gcs_status_t status,
  output gcs_cmd_t    cmd
);

  gcs_state_t           state;
  gcs_state_t           state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;
  logic                 rsp_valid_next;
  logic                 accept;
  logic                 out_free;

  assign accept   = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: begin
        if (accept && req_last) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SUB;
      end
      ST_SUB: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = status.need_div ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    req_ready    = 1'b0;
    div_cnt_next = div_cnt;
    case (state)
      ST_ACCUM: begin
        req_ready    = 1'b1;
        cmd.accum    = req_valid;
        div_cnt_next = '0;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_SUB: begin
        cmd.sub = 1'b1;
      end
      ST_CMP: begin
        cmd.cmp = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
      end
      ST_EMIT: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      div_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  `GCS_ASSERT_NEXT(a_last_starts_finish, accept && req_last, state == ST_MUL,
    "last request did not start the finishing sequence")
  `GCS_ASSERT_NEXT(a_div_length, state == ST_DIV && div_cnt == DIV_CNT_W'(DIV_STEPS - 1),
    state == ST_EMIT, "divider did not stop after the last quotient bit")
  `GCS_ASSERT_NEXT(a_emit_loads, state == ST_EMIT && out_free,
    rsp_valid && state == ST_ACCUM, "result was not handed to the output register")
  `GCS_ASSERT_SAME(a_div_entry, state == ST_DIV && div_cnt == '0,
    $past(state) == ST_CMP, "divider entered without the compare step")

endmodule

// ----- sv/gini_coefficient_sorted.sv -----
// ----------------------------------------------------------------------------
// Gini coefficient of a sorted run
// Accumulates a run of ascending samples and reports its Gini coefficient.
// ----------------------------------------------------------------------------
// While a run is open, one request is taken every cycle: each costs one
// index-by-sample multiply-add into the weighted total. The request marked
// last closes the run. The block then forms n*T, forms 2W - (n+1)T and
// compares that difference with zero and with n*T, in the states ST_MUL,
// ST_SUB and ST_CMP. When the result lies strictly between 0 and 1, it then
// runs a restoring divider that yields one quotient bit per cycle. After
// that the result moves into the output register. No request is taken
// while the run is being finished. A result waiting in the output
// register does not block the next run from accumulating, but the move of
// the next result into the output register waits until the earlier one has
// been taken.
module gini_coefficient_sorted import gcs_pkg::*; #(
  parameter int MAX_N       = 4096,
  parameter int SAMPLE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  gcs_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output gcs_rsp_t rsp
);

  gcs_cmd_t    cmd;
  gcs_status_t status;

  gcs_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_last  (req.is_last),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  gcs_datapath #(
    .MAX_N       (MAX_N),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .req    (req),
    .status (status),
    .rsp    (rsp)
  );

endmodule

// ----- sim/gini_coefficient_sorted_test.sv -----
// ----------------------------------------------------------------------------
// Gini coefficient block: testbench
// Sends runs of samples and checks every reported coefficient against an
// in-bench predictor that keeps its own totals. Directed runs cover single
// samples, zero totals, equal and unsorted samples and a long run of large
// samples. Random runs follow under varying sender and receiver pressure.
// ----------------------------------------------------------------------------
module gini_coefficient_sorted_test;
  import gcs_pkg::*;

  localparam int MAX_RUN       = 4096;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS  = 520;
  localparam int REPORT_LIMIT  = 10;
  localparam int RUN_DEPTH     = 64;

  typedef enum int {
    SHAPE_FULL,
    SHAPE_SMALL,
    SHAPE_SCALED,
    SHAPE_PEAK,
    SHAPE_UNSORTED
  } run_shape_t;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  gcs_req_t req;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  gcs_rsp_t rsp;

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int report_count;
  int sent_items;

  gcs_rsp_t    expected_gini[$];
  gcs_rsp_t    oldest_gini;
  logic [12:0] acc_count    = '0;
  logic [63:0] acc_weighted = '0;
  logic [63:0] acc_total    = '0;
  logic        acc_dropped  = 1'b0;
  logic [31:0] run_vals [0:RUN_DEPTH-1];

  gini_coefficient_sorted i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic predict_sample(input gcs_req_t r);
    logic [63:0]  lhs;
    logic [63:0]  sub;
    logic [63:0]  den;
    logic [63:0]  num;
    logic [127:0] quot;
    gcs_rsp_t     res;
    if (acc_count < MAX_RUN) begin
      acc_count    = acc_count + 13'd1;
      acc_weighted = acc_weighted + 64'(acc_count) * 64'(r.sample);
      acc_total    = acc_total + 64'(r.sample);
    end else begin
      acc_dropped = 1'b1;
    end
    if (r.is_last) begin
      res = '0;
      res.item_count     = acc_count;
      res.count_overflow = acc_dropped;
      if (acc_count == 0 || acc_total == 0) begin
        res.zero_total = 1'b1;
      end else begin
        lhs = acc_weighted << 1;
        sub = (64'(acc_count) + 64'd1) * acc_total;
        den = 64'(acc_count) * acc_total;
        if (lhs > sub) begin
          num = lhs - sub;
          if (num >= den) begin
            res.gini_q16 = Q_ONE;
          end else begin
            quot = {48'd0, num, 16'd0} / {64'd0, den};
            res.gini_q16 = quot[GINI_W-1:0];
          end
        end
      end
      expected_gini.push_back(res);
      acc_count    = '0;
      acc_weighted = '0;
      acc_total    = '0;
      acc_dropped  = 1'b0;
    end
  endtask

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_gini.size() == 0) begin
        fail_count++;
        if (report_count < REPORT_LIMIT) begin
          $display("unexpected response: gini=%0d count=%0d zero=%0b ovf=%0b",
                   rsp.gini_q16, rsp.item_count, rsp.zero_total, rsp.count_overflow);
        end
        report_count++;
      end else begin
        oldest_gini = expected_gini.pop_front();
        if (rsp.gini_q16 !== oldest_gini.gini_q16 ||
            rsp.item_count !== oldest_gini.item_count ||
            rsp.zero_total !== oldest_gini.zero_total ||
            rsp.count_overflow !== oldest_gini.count_overflow) begin
          fail_count++;
          if (report_count < REPORT_LIMIT) begin
            $display("mismatch: expected gini=%0d count=%0d zero=%0b ovf=%0b,",
                     oldest_gini.gini_q16, oldest_gini.item_count,
                     oldest_gini.zero_total, oldest_gini.count_overflow,
                     " got gini=%0d count=%0d zero=%0b ovf=%0b",
                     rsp.gini_q16, rsp.item_count, rsp.zero_total, rsp.count_overflow);
          end
          report_count++;
        end
      end
    end
    if (!rst && req_valid && req_ready) begin
      predict_sample(req);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // One request; valid is held until the block takes it.
  task automatic send_sample(input logic [31:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req.sample  = value;
    req.is_last = last;
    req_valid   = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
    req_valid = 1'b0;
    sent_items++;
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) begin
      send_sample(run_vals[i], i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (expected_gini.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic fill_run(input int len, input run_shape_t shape);
    logic [31:0] hold;
    int          j;
    int          shift;
    shift = $urandom_range(31);
    for (int i = 0; i < len; i++) begin
      case (shape)
        SHAPE_SMALL: begin
          run_vals[i] = $urandom_range(15);
        end
        SHAPE_SCALED: begin
          run_vals[i] = $urandom >> shift;
        end
        SHAPE_PEAK: begin
          run_vals[i] = (i == len - 1) ? $urandom : $urandom_range(3);
        end
        default: begin
          run_vals[i] = $urandom;
        end
      endcase
    end
    if (shape != SHAPE_UNSORTED) begin
      for (int i = 1; i < len; i++) begin
        hold = run_vals[i];
        j = i - 1;
        while (j >= 0 && run_vals[j] > hold) begin
          run_vals[j + 1] = run_vals[j];
          j--;
        end
        run_vals[j + 1] = hold;
      end
    end
  endtask

  task automatic test_single_samples();
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0001, 1'b1);
    send_sample(32'h8000_0000, 1'b1);
    wait_drained();
  endtask

  task automatic test_zero_total();
    send_sample(32'h0, 1'b1);
    send_sample(32'h0, 1'b0);
    send_sample(32'h0, 1'b0);
    send_sample(32'h0, 1'b1);
    wait_drained();
  endtask

  task automatic test_equal_samples();
    for (int i = 0; i < 4; i++) send_sample(32'd7, i == 3);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_skewed_runs();
    send_sample(32'h0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 5; i++) send_sample(32'(i + 1), i == 4);
    wait_drained();
  endtask

  task automatic test_unsorted();
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h1, 1'b1);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b0);
    send_sample(32'h0, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_run();
    recv_stall_pct = 50;
    for (int i = 1; i <= RUN_DEPTH; i++) begin
      send_sample(32'hFFFF_FFFF - 32'(RUN_DEPTH - i), i == RUN_DEPTH);
    end
    wait_drained();
    recv_stall_pct = 0;
  endtask

  task automatic random_phase(input int items, input int idle_pct, input int stall_pct);
    int         stop_at;
    int         len;
    int         pick;
    run_shape_t shape;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at = sent_items + items;
    while (sent_items < stop_at) begin
      len  = ($urandom_range(99) < 90) ? $urandom_range(1, 12)
                                       : $urandom_range(13, RUN_DEPTH);
      pick = $urandom_range(99);
      if (pick < 30)      shape = SHAPE_FULL;
      else if (pick < 50) shape = SHAPE_SMALL;
      else if (pick < 75) shape = SHAPE_SCALED;
      else if (pick < 90) shape = SHAPE_PEAK;
      else                shape = SHAPE_UNSORTED;
      fill_run(len, shape);
      send_run(len);
    end
    wait_drained();
  endtask

  task automatic test_random_runs();
    random_phase(RANDOM_ITEMS / 4, 0, 0);
    random_phase(RANDOM_ITEMS / 4, 87, 0);
    random_phase(RANDOM_ITEMS / 4, 0, 87);
    random_phase(RANDOM_ITEMS / 4, 10, 10);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fail_count     = 0;
    report_count   = 0;
    sent_items     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_samples();
    test_zero_total();
    test_equal_samples();
    test_skewed_runs();
    test_unsorted();
    test_long_run();
    test_random_runs();
    wait_drained();

    if (fail_count == 0 && expected_gini.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/gcs_pkg.sv
sv/gcs_datapath.sv
sv/gcs_controller.sv
sv/gini_coefficient_sorted.sv
sim/gini_coefficient_sorted_test.sv
